// File: rtl/tagged_record_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// tagged_record_extractor_top_macros
// Assertion macros used by the tagged record extractor checker.
// ----------------------------------------------------------------------------
`ifndef TAGGED_RECORD_EXTRACTOR_TOP_MACROS_SVH
`define TAGGED_RECORD_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define TRE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tagged_record_extractor assertion failed");

// next-cycle implication, masked during reset
`define TRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tagged_record_extractor assertion failed");

// next-cycle implication, also checked while reset is applied
`define TRE_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("tagged_record_extractor reset assertion failed");

`endif

// File: rtl/tre_pkg.sv
// ----------------------------------------------------------------------------
// tre_pkg
// Types and constants for the tagged record extractor.
// ----------------------------------------------------------------------------
package tre_pkg;

    localparam int COUNT_BITS = 16;
    localparam int MAX_TAG    = 8;
    localparam int TAG_LEN_W  = 4;
    localparam int POS_W      = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [63:0]          TAG_CHARS_RST  = 64'd4919433040666772818;
    localparam logic [TAG_LEN_W-1:0] TAG_LENGTH_RST = TAG_LEN_W'(MAX_TAG);

    // register index, taken from paddr[3]
    localparam logic REG_TAG_CHARS  = 1'b0;
    localparam logic REG_TAG_LENGTH = 1'b1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_TAG    = 3'd0,
        PH_BLANKS = 3'd1,
        PH_DIGITS = 3'd2,
        PH_COLON  = 3'd3,
        PH_AFTER  = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data_byte;
        logic       record_end;
    } tre_result_t;

endpackage

// File: rtl/tre_parser.sv
// ----------------------------------------------------------------------------
// tre_parser
// Record parse state and the per-byte step: tag match, count, data pass-out.
// ----------------------------------------------------------------------------
module tre_parser
    import tre_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           in_byte,
    input  logic                 new_file,
    input  logic [63:0]          tag_chars,
    input  logic [TAG_LEN_W-1:0] tag_length,
    output tre_result_t          result
);

    phase_t                  phase_reg, phase_next;
    logic [POS_W-1:0]        tag_pos_reg, tag_pos_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;

    phase_t                  ph_w;
    logic [POS_W-1:0]        pos_w;
    logic [COUNT_BITS-1:0]   cnt_w;
    logic [7:0]              want;
    logic [TAG_LEN_W-1:0]    eff_len;
    logic                    tag_hit;
    logic                    tag_done;
    logic                    is_blank;
    logic                    is_digit;
    logic [COUNT_BITS+3:0]   cnt_x10;
    logic [COUNT_BITS+3:0]   cnt_acc;
    logic [COUNT_BITS-1:0]   cnt_sat;
    logic [COUNT_BITS-1:0]   cnt_dec;
    logic [3:0]              digit;

    // new_file clears the parse before this byte is looked at
    assign ph_w  = new_file ? PH_TAG : phase_reg;
    assign pos_w = new_file ? '0 : tag_pos_reg;
    assign cnt_w = new_file ? '0 : count_reg;

    assign want = tag_chars[{pos_w, 3'b000} +: 8];

    always_comb begin
        if (tag_length == '0) begin
            eff_len = TAG_LEN_W'(1);
        end else if (tag_length > TAG_LEN_W'(MAX_TAG)) begin
            eff_len = TAG_LEN_W'(MAX_TAG);
        end else begin
            eff_len = tag_length;
        end
    end

    assign tag_hit  = (in_byte == want);
    assign tag_done = ({1'b0, pos_w} + TAG_LEN_W'(1)) >= eff_len;
    assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = 4'(in_byte - CH_ZERO);

    // count * 10 + digit, clipped to all ones
    assign cnt_x10 = {1'b0, cnt_w, 3'b000} + {3'b000, cnt_w, 1'b0};
    assign cnt_acc = cnt_x10 + (COUNT_BITS+4)'(digit);
    assign cnt_sat = (cnt_acc[COUNT_BITS+3:COUNT_BITS] != '0) ? '1 : cnt_acc[COUNT_BITS-1:0];
    assign cnt_dec = (cnt_w != '0) ? cnt_w - COUNT_BITS'(1) : cnt_w;

    // next phase
    always_comb begin
        phase_next = ph_w;
        unique case (ph_w)
            PH_TAG: begin
                if (tag_hit && tag_done) phase_next = PH_BLANKS;
            end
            PH_BLANKS: begin
                if (!is_blank) phase_next = is_digit ? PH_DIGITS : PH_TAG;
            end
            PH_DIGITS: begin
                if (!is_digit) phase_next = is_blank ? PH_COLON : PH_TAG;
            end
            PH_COLON: begin
                if (in_byte == CH_COLON) phase_next = PH_AFTER;
            end
            PH_AFTER: begin
                phase_next = (is_blank && cnt_w != '0) ? PH_DATA : PH_TAG;
            end
            PH_DATA: begin
                if (cnt_dec == '0) phase_next = PH_TAG;
            end
            default: phase_next = PH_TAG;
        endcase
    end

    // tag position, count and result
    always_comb begin
        tag_pos_next = pos_w;
        count_next   = cnt_w;
        result       = '{emit: 1'b0, data_byte: in_byte, record_end: 1'b0};
        unique case (ph_w)
            PH_TAG: begin
                if (tag_hit && !tag_done) begin
                    tag_pos_next = pos_w + POS_W'(1);
                end else begin
                    tag_pos_next = '0;
                end
            end
            PH_BLANKS: begin
                if (!is_blank && is_digit) count_next = COUNT_BITS'(digit);
            end
            PH_DIGITS: begin
                if (is_digit) count_next = cnt_sat;
            end
            PH_COLON, PH_AFTER: begin
                count_next = cnt_w;
            end
            PH_DATA: begin
                count_next        = cnt_dec;
                result.emit       = 1'b1;
                result.record_end = (cnt_dec == '0);
            end
            default: begin
                tag_pos_next = '0;
                count_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TAG;
            tag_pos_reg <= '0;
            count_reg   <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            tag_pos_reg <= tag_pos_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: rtl/tagged_record_extractor_top.sv
// ----------------------------------------------------------------------------
// tagged_record_extractor_top
// Pulls the data bytes of tagged, counted records out of a byte stream.
// ----------------------------------------------------------------------------
// channel   dir  handshake                payload
// s_axis    in   s_axis_tvalid/tready     tdata = in_byte, tuser = new_file
// m_axis    out  m_axis_tvalid/tready     tdata = data_byte, tlast = record_end
// apb       in   psel/penable/pready      paddr 0 tag_chars, 8 tag_length
//
// One byte per cycle sustained while m_axis is not stalled; a byte is latched in
// the input register, then stepped through the parser into the output register.
// Only the parse state loop (phase, tag position, count) sets the rate.
// A stalled m_axis holds the output register and a full input register, and
// drops s_axis_tready. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module tagged_record_extractor_top
    import tre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  logic                  s_axis_tuser,   // [0] new_file

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] data_byte
    output logic                  m_axis_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_new_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_data_reg;
    logic                  out_last_reg;
    logic [63:0]           tag_chars_reg;
    logic [TAG_LEN_W-1:0]  tag_length_reg;

    logic                  advance;
    logic                  step_en;
    logic                  cfg_wr;
    logic                  reg_sel;
    tre_result_t           result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_TAG_CHARS:  prdata = tag_chars_reg;
            REG_TAG_LENGTH: prdata = APB_DATA_W'(tag_length_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_chars_reg  <= TAG_CHARS_RST;
            tag_length_reg <= TAG_LENGTH_RST;
        end else if (cfg_wr) begin
            if (reg_sel == REG_TAG_CHARS) tag_chars_reg <= pwdata;
            if (reg_sel == REG_TAG_LENGTH) tag_length_reg <= pwdata[TAG_LEN_W-1:0];
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_new_reg  <= s_axis_tuser;
        end
    end

    tre_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .in_byte    (in_byte_reg),
        .new_file   (in_new_reg),
        .tag_chars  (tag_chars_reg),
        .tag_length (tag_length_reg),
        .result     (result)
    );

    // output register; a byte that yields nothing leaves it empty
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = step_en && result.emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && result.emit) begin
            out_data_reg <= result.data_byte;
            out_last_reg <= result.record_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/tre_checker.sv
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks for the tagged record extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "tagged_record_extractor_top_macros.svh"

module tre_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata,   // [7:0] data_byte
    input logic                  m_axis_tlast
);

    // stalled result holds
    `TRE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // nothing pending right after reset
    `TRE_ASSERT_RST(a_rst_empty, !aresetn, !m_axis_tvalid)

    // a fresh result comes from an earlier s_axis transaction, via the input register
    `TRE_ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready, 2))

    // a draining output never blocks the input side
    `TRE_ASSERT_IMPL(a_no_block, m_axis_tready, s_axis_tready)

endmodule

bind tagged_record_extractor_top tre_checker u_tre_checker (.*);
